// ===== rtl/core/rcfd_pkg.sv =====
// ----------------------------------------------------------------------------
// rcfd_pkg
// shared types and constants of the resyncing crc frame deframer
// ----------------------------------------------------------------------------
package rcfd_pkg;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_SCAN = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [1:0] CFG_SHORT_START = 2'd0;
  localparam logic [1:0] CFG_LONG_START  = 2'd1;
  localparam logic [1:0] CFG_END_BYTE    = 2'd2;

  localparam logic [7:0]  SHORT_START_RST = 8'd2;
  localparam logic [7:0]  LONG_START_RST  = 8'd3;
  localparam logic [7:0]  END_BYTE_RST    = 8'd3;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_MSB  = 16'h8000;
  localparam logic [15:0] CRC_INIT = 16'h0000;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic [8:0] read_index;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [9:0]  payload_length;
    logic [7:0]  payload_byte;
    logic [31:0] resync_drops;
    logic [31:0] crc_errors;
    logic [10:0] fill_count;
  } out_t;

endpackage

// ===== rtl/core/resyncing_crc_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// resyncing_crc_frame_deframer
// receive buffer with frame search, crc-16/xmodem check and payload store
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Every command gives
// exactly one result on out_payload, marked by out_valid for one cycle; the
// receiver cannot stall, so results are never held back.
// The receive bytes sit in a circular buffer ram, the extracted payload in a
// second ram. Push and no-action commands return a result in the cycle after
// the transfer; a payload read passes through ST_PREAD for one ram read.
// A scan walks the buffer offset by offset through the single read port: an
// offset without a start byte is skipped; at a start byte the length is read
// and checked; a complete candidate's body runs through the crc, then its crc
// and end bytes are compared, and a good frame's body is copied into the
// payload ram. The cfg port is always ready; the user must see that its
// registers are written only while idle, which the block does not enforce.
// Reset clears fill level, payload length and counters and returns the start
// and end byte registers to their defaults; ram contents need no clearing.
// ----------------------------------------------------------------------------
module resyncing_crc_frame_deframer #(
  parameter int BUFFER_DEPTH = 1024,
  parameter int MAX_PAYLOAD  = 512
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  rcfd_pkg::in_t   in_payload,
  output logic            out_valid,
  output rcfd_pkg::out_t  out_payload,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [7:0]      cfg_data
);
  import rcfd_pkg::*;

  localparam int AW  = $clog2(BUFFER_DEPTH);
  localparam int FW  = $clog2(BUFFER_DEPTH + 1);
  localparam int SW  = FW + 1;
  localparam int CW  = ((FW > 17) ? FW : 17) + 1;
  localparam int PW  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int PLW = $clog2(MAX_PAYLOAD + 1);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_RD0   = 11'b00000000010,
    ST_RD1   = 11'b00000000100,
    ST_RD2   = 11'b00000001000,
    ST_LCHK  = 11'b00000010000,
    ST_BODY  = 11'b00000100000,
    ST_CHI   = 11'b00001000000,
    ST_CLO   = 11'b00010000000,
    ST_CEND  = 11'b00100000000,
    ST_COPY  = 11'b01000000000,
    ST_PREAD = 11'b10000000000
  } st_t;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                              input logic [FW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(BUFFER_DEPTH)) begin
      s = s - SW'(BUFFER_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [15:0] crc_upd(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

  st_t             state_r, state_nxt;
  logic            emit_r, emit_nxt;
  logic [7:0]      ss_r, ls_r, eb_r;
  logic [AW-1:0]   head_r, head_nxt;
  logic [FW-1:0]   fill_r, fill_nxt;
  logic [PLW-1:0]  held_len_r, held_len_nxt;
  logic [31:0]     drop_r, drop_nxt;
  logic [31:0]     cerr_r, cerr_nxt;
  logic            found_r, found_nxt;
  logic [7:0]      pbyte_r, pbyte_nxt;
  logic            rd_ok_r, rd_ok_nxt;
  logic [FW-1:0]   pos_r, pos_nxt;
  logic [FW-1:0]   rd_off_r, rd_off_nxt;
  logic [FW-1:0]   keep_r, keep_nxt;
  logic            have_inc_r, have_inc_nxt;
  logic            long_r, long_nxt;
  logic [15:0]     len_r, len_nxt;
  logic [PLW-1:0]  cnt_r, cnt_nxt;
  logic [15:0]     crc_r, crc_nxt;
  logic [7:0]      chi_r, chi_nxt;
  logic [7:0]      clo_r, clo_nxt;

  logic            b_we;
  logic [AW-1:0]   b_waddr, b_raddr;
  logic [7:0]      b_rdata;
  logic            p_we;
  logic [PW-1:0]   p_waddr, p_raddr;
  logic [7:0]      p_rdata;
  logic [PW+8:0]   idx_ext;

  logic            adv, mark, is_s, is_l, cnt_last;
  logic [FW-1:0]   avail;
  logic [CW-1:0]   total_w;
  logic [FW-1:0]   rem;

  assign idx_ext = {{PW{1'b0}}, in_payload.read_index};
  assign p_raddr = idx_ext[PW-1:0];
  assign avail   = fill_r - pos_r;
  assign total_w = CW'(len_r) + (long_r ? CW'(6) : CW'(5));
  assign rem     = FW'(CW'(pos_r) + total_w);
  assign is_s    = (b_rdata == ss_r);
  assign is_l    = (b_rdata == ls_r) && !is_s;
  assign cnt_last = ((17'(cnt_r) + 17'd1) == 17'(len_r));

  always_comb begin
    state_nxt    = state_r;
    emit_nxt     = 1'b0;
    head_nxt     = head_r;
    fill_nxt     = fill_r;
    held_len_nxt = held_len_r;
    drop_nxt     = drop_r;
    cerr_nxt     = cerr_r;
    found_nxt    = found_r;
    pbyte_nxt    = pbyte_r;
    rd_ok_nxt    = rd_ok_r;
    pos_nxt      = pos_r;
    rd_off_nxt   = rd_off_r;
    keep_nxt     = keep_r;
    have_inc_nxt = have_inc_r;
    long_nxt     = long_r;
    len_nxt      = len_r;
    cnt_nxt      = cnt_r;
    crc_nxt      = crc_r;
    chi_nxt      = chi_r;
    clo_nxt      = clo_r;
    b_we         = 1'b0;
    b_waddr      = wrap_add(head_r, fill_r);
    p_we         = 1'b0;
    p_waddr      = cnt_r[PW-1:0];
    adv          = 1'b0;
    mark         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          found_nxt = 1'b0;
          pbyte_nxt = 8'h00;
          case (in_payload.operation)
            OP_PUSH: begin
              b_we = 1'b1;
              if (fill_r >= FW'(BUFFER_DEPTH)) begin
                head_nxt = wrap_add(head_r, FW'(1));
                drop_nxt = drop_r + 32'd1;
              end else begin
                fill_nxt = fill_r + FW'(1);
              end
              emit_nxt = 1'b1;
            end
            OP_SCAN: begin
              have_inc_nxt = 1'b0;
              keep_nxt     = fill_r;
              pos_nxt      = '0;
              rd_off_nxt   = '0;
              if (fill_r == '0) begin
                emit_nxt = 1'b1;
              end else begin
                state_nxt = ST_RD0;
              end
            end
            OP_READ: begin
              rd_ok_nxt = (32'(in_payload.read_index) < 32'(held_len_r)) &&
                          (32'(in_payload.read_index) < MAX_PAYLOAD);
              state_nxt = ST_PREAD;
            end
            default: begin
              emit_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_RD0: begin
        rd_off_nxt = rd_off_r + FW'(1);
        if (avail < FW'(5)) begin
          mark = is_s || is_l;
          adv  = 1'b1;
        end else if (is_s) begin
          long_nxt  = 1'b0;
          state_nxt = ST_RD1;
        end else if (is_l) begin
          if (avail < FW'(6)) begin
            mark = 1'b1;
            adv  = 1'b1;
          end else begin
            long_nxt  = 1'b1;
            state_nxt = ST_RD1;
          end
        end else begin
          adv = 1'b1;
        end
      end
      ST_RD1: begin
        if (long_r) begin
          len_nxt    = {b_rdata, 8'h00};
          rd_off_nxt = rd_off_r + FW'(1);
          state_nxt  = ST_RD2;
        end else begin
          len_nxt   = {8'h00, b_rdata};
          state_nxt = ST_LCHK;
        end
      end
      ST_RD2: begin
        len_nxt   = {len_r[15:8], b_rdata};
        state_nxt = ST_LCHK;
      end
      ST_LCHK: begin
        if ((len_r == 16'h0000) || (32'(len_r) > MAX_PAYLOAD)) begin
          adv = 1'b1;
        end else if (CW'(avail) < total_w) begin
          mark = 1'b1;
          adv  = 1'b1;
        end else begin
          cnt_nxt    = '0;
          crc_nxt    = CRC_INIT;
          rd_off_nxt = rd_off_r + FW'(1);
          state_nxt  = ST_BODY;
        end
      end
      ST_BODY: begin
        crc_nxt    = crc_upd(crc_r, b_rdata);
        cnt_nxt    = cnt_r + PLW'(1);
        rd_off_nxt = rd_off_r + FW'(1);
        if (cnt_last) begin
          state_nxt = ST_CHI;
        end
      end
      ST_CHI: begin
        chi_nxt    = b_rdata;
        rd_off_nxt = rd_off_r + FW'(1);
        state_nxt  = ST_CLO;
      end
      ST_CLO: begin
        clo_nxt    = b_rdata;
        rd_off_nxt = rd_off_r + FW'(1);
        state_nxt  = ST_CEND;
      end
      ST_CEND: begin
        if ((b_rdata == eb_r) && ({chi_r, clo_r} == crc_r)) begin
          cnt_nxt    = '0;
          rd_off_nxt = pos_r + (long_r ? FW'(3) : FW'(2));
          state_nxt  = ST_COPY;
        end else begin
          cerr_nxt = cerr_r + 32'd1;
          adv      = 1'b1;
        end
      end
      ST_COPY: begin
        p_we       = 1'b1;
        cnt_nxt    = cnt_r + PLW'(1);
        rd_off_nxt = rd_off_r + FW'(1);
        if (cnt_last) begin
          held_len_nxt = len_r[PLW-1:0];
          drop_nxt     = drop_r + 32'(pos_r);
          head_nxt     = wrap_add(head_r, rem);
          fill_nxt     = fill_r - rem;
          found_nxt    = 1'b1;
          emit_nxt     = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_PREAD: begin
        pbyte_nxt = rd_ok_r ? p_rdata : 8'h00;
        emit_nxt  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // first incomplete candidate sets where the kept bytes begin
    if (mark && !have_inc_r) begin
      have_inc_nxt = 1'b1;
      keep_nxt     = pos_r;
    end
    if (adv) begin
      if ((pos_r + FW'(1)) == fill_r) begin
        drop_nxt  = drop_nxt + 32'(keep_nxt);
        head_nxt  = wrap_add(head_r, keep_nxt);
        fill_nxt  = fill_r - keep_nxt;
        emit_nxt  = 1'b1;
        state_nxt = ST_IDLE;
      end else begin
        pos_nxt    = pos_r + FW'(1);
        rd_off_nxt = pos_r + FW'(1);
        state_nxt  = ST_RD0;
      end
    end
    b_raddr = wrap_add(head_r, rd_off_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      emit_r     <= 1'b0;
      ss_r       <= SHORT_START_RST;
      ls_r       <= LONG_START_RST;
      eb_r       <= END_BYTE_RST;
      head_r     <= '0;
      fill_r     <= '0;
      held_len_r <= '0;
      drop_r     <= '0;
      cerr_r     <= '0;
      found_r    <= 1'b0;
      pbyte_r    <= 8'h00;
      have_inc_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      emit_r     <= emit_nxt;
      head_r     <= head_nxt;
      fill_r     <= fill_nxt;
      held_len_r <= held_len_nxt;
      drop_r     <= drop_nxt;
      cerr_r     <= cerr_nxt;
      found_r    <= found_nxt;
      pbyte_r    <= pbyte_nxt;
      have_inc_r <= have_inc_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SHORT_START: ss_r <= cfg_data;
          CFG_LONG_START:  ls_r <= cfg_data;
          CFG_END_BYTE:    eb_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_ok_r  <= rd_ok_nxt;
    pos_r    <= pos_nxt;
    rd_off_r <= rd_off_nxt;
    keep_r   <= keep_nxt;
    long_r   <= long_nxt;
    len_r    <= len_nxt;
    cnt_r    <= cnt_nxt;
    crc_r    <= crc_nxt;
    chi_r    <= chi_nxt;
    clo_r    <= clo_nxt;
  end

  rcfd_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_DEPTH)
  ) u_byte_ram (
    .clk  (clk),
    .we   (b_we),
    .waddr(b_waddr),
    .wdata(in_payload.data_byte),
    .raddr(b_raddr),
    .rdata(b_rdata)
  );

  rcfd_ram #(
    .WIDTH(8),
    .DEPTH(MAX_PAYLOAD)
  ) u_payload_ram (
    .clk  (clk),
    .we   (p_we),
    .waddr(p_waddr),
    .wdata(b_rdata),
    .raddr(p_raddr),
    .rdata(p_rdata)
  );

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = emit_r;

  always_comb begin
    out_payload.found          = found_r;
    out_payload.payload_length = 10'(held_len_r);
    out_payload.payload_byte   = pbyte_r;
    out_payload.resync_drops   = drop_r;
    out_payload.crc_errors     = cerr_r;
    out_payload.fill_count     = 11'(fill_r);
  end

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_push_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_payload.operation == OP_PUSH)) |=> out_valid)
    else $error("push transfer without result next cycle");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(BUFFER_DEPTH))
    else $error("fill level beyond buffer depth");

  a_scan_no_growth: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && $past(busy)) |-> (fill_r == $past(fill_r)) || !busy)
    else $error("fill level changed in the middle of a scan");

endmodule

// ===== rtl/core/rcfd_ram.sv =====
// ----------------------------------------------------------------------------
// rcfd_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module rcfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== tb/rcfd_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rcfd_result_checker
// Watches the command, result and cfg channels of the deframer. Keeps its
// own copy of the receive buffer, payload store, counters and start/end
// registers, works out the status for every accepted command and compares
// each result field by field with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module rcfd_result_checker
  import rcfd_pkg::*;
#(
  parameter int BUFFER_DEPTH = 1024,
  parameter int MAX_PAYLOAD  = 512
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  in_t        in_payload,
  input  logic       out_valid,
  input  out_t       out_payload,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         fail_count,
  output int         pending
);

  typedef enum int {CAND_NONE, CAND_INCOMPLETE, CAND_BAD, CAND_GOOD} cand_e;

  logic [7:0]  rx_buf [0:BUFFER_DEPTH-1];
  logic [7:0]  held_bytes [0:MAX_PAYLOAD-1];
  int unsigned rx_fill;
  int unsigned held_len;
  logic [31:0] drop_total;
  logic [31:0] crc_err_total;
  logic [7:0]  short_start;
  logic [7:0]  long_start;
  logic [7:0]  end_mark;
  out_t        status_q [$];

  initial fail_count = 0;
  initial pending = 0;

  function automatic logic [15:0] crc_of(int unsigned from, int unsigned n);
    logic [15:0] crc;
    crc = CRC_INIT;
    for (int unsigned i = 0; i < n; i++) begin
      crc = crc ^ {rx_buf[from + i], 8'h00};
      for (int b = 0; b < 8; b++) begin
        if ((crc & CRC_MSB) != 16'h0) crc = (crc << 1) ^ CRC_POLY;
        else crc = crc << 1;
      end
    end
    return crc;
  endfunction

  function automatic cand_e classify(input int unsigned pos, output int unsigned body_at,
                                     output int unsigned body_len, output int unsigned total);
    int unsigned avail;
    int unsigned head;
    int unsigned crc_at;
    logic [7:0]  first;
    logic [15:0] wire_crc;
    avail = rx_fill - pos;
    first = rx_buf[pos];
    body_at = 0;
    body_len = 0;
    total = 0;
    if (avail < 5)
      return (first == short_start || first == long_start) ? CAND_INCOMPLETE : CAND_NONE;
    if (first == short_start) begin
      head = 2;
      body_len = rx_buf[pos + 1];
    end else if (first == long_start) begin
      if (avail < 6) return CAND_INCOMPLETE;
      head = 3;
      body_len = {rx_buf[pos + 1], rx_buf[pos + 2]};
    end else begin
      return CAND_NONE;
    end
    if (body_len == 0 || body_len > MAX_PAYLOAD) return CAND_NONE;
    body_at = pos + head;
    total = head + body_len + 3;
    if (avail < total) return CAND_INCOMPLETE;
    crc_at = body_at + body_len;
    wire_crc = {rx_buf[crc_at], rx_buf[crc_at + 1]};
    if (rx_buf[crc_at + 2] != end_mark || wire_crc != crc_of(body_at, body_len))
      return CAND_BAD;
    return CAND_GOOD;
  endfunction

  task automatic drop_front(int unsigned n);
    if (n > rx_fill) n = rx_fill;
    for (int unsigned i = 0; i + n < rx_fill; i++) rx_buf[i] = rx_buf[i + n];
    rx_fill = rx_fill - n;
  endtask

  task automatic scan_for_frame(output logic hit);
    int unsigned kept_at;
    int unsigned body_at;
    int unsigned body_len;
    int unsigned total;
    logic        have_partial;
    cand_e       kind;
    kept_at = rx_fill;
    have_partial = 1'b0;
    hit = 1'b0;
    for (int unsigned pos = 0; pos < rx_fill; pos++) begin
      kind = classify(pos, body_at, body_len, total);
      if (kind == CAND_GOOD) begin
        for (int unsigned i = 0; i < body_len; i++) held_bytes[i] = rx_buf[body_at + i];
        held_len = body_len;
        drop_total = drop_total + pos;
        drop_front(pos + total);
        hit = 1'b1;
        return;
      end
      if (kind == CAND_INCOMPLETE && !have_partial) begin
        have_partial = 1'b1;
        kept_at = pos;
      end
      if (kind == CAND_BAD) crc_err_total = crc_err_total + 1;
    end
    drop_total = drop_total + kept_at;
    drop_front(kept_at);
  endtask

  task automatic predict_status(input in_t cmd, output out_t st);
    logic hit;
    st = '0;
    case (cmd.operation)
      OP_PUSH: begin
        if (rx_fill >= BUFFER_DEPTH) begin
          drop_front(1);
          drop_total = drop_total + 1;
        end
        rx_buf[rx_fill] = cmd.data_byte;
        rx_fill = rx_fill + 1;
      end
      OP_SCAN: begin
        scan_for_frame(hit);
        st.found = hit;
      end
      OP_READ: begin
        if (cmd.read_index < held_len) st.payload_byte = held_bytes[cmd.read_index];
      end
      default: ;
    endcase
    st.payload_length = held_len[9:0];
    st.resync_drops   = drop_total;
    st.crc_errors     = crc_err_total;
    st.fill_count     = rx_fill[10:0];
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $display("%0t %s expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    out_t st;
    out_t exp_st;
    if (!rst_n) begin
      rx_fill = 0;
      held_len = 0;
      drop_total = '0;
      crc_err_total = '0;
      short_start = SHORT_START_RST;
      long_start = LONG_START_RST;
      end_mark = END_BYTE_RST;
      status_q.delete();
    end else begin
      if (out_valid) begin
        if (status_q.size() == 0) begin
          fail_count++;
          $display("%0t unexpected result expected none actual %h", $time, out_payload);
        end else begin
          exp_st = status_q.pop_front();
          check_field("found", exp_st.found, out_payload.found);
          check_field("payload_length", exp_st.payload_length, out_payload.payload_length);
          check_field("payload_byte", exp_st.payload_byte, out_payload.payload_byte);
          check_field("resync_drops", exp_st.resync_drops, out_payload.resync_drops);
          check_field("crc_errors", exp_st.crc_errors, out_payload.crc_errors);
          check_field("fill_count", exp_st.fill_count, out_payload.fill_count);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SHORT_START: short_start = cfg_data;
          CFG_LONG_START:  long_start = cfg_data;
          CFG_END_BYTE:    end_mark = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        predict_status(in_payload, st);
        status_q = {status_q, st};
      end
    end
    pending <= status_q.size();
  end

endmodule

// ===== tb/resyncing_crc_frame_deframer_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// resyncing_crc_frame_deframer_test
// Drives byte pushes, scans, payload reads and no-action commands with random
// gaps, through several start/end byte settings: well-formed frames with
// noise in front, frames with bad crc, bad end byte or cut short, bad
// lengths, a buffer overflow and a maximum length frame. A checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module resyncing_crc_frame_deframer_test;
  import rcfd_pkg::*;

  localparam int BUFFER_DEPTH   = 1024;
  localparam int MAX_PAYLOAD    = 512;
  localparam int TARGET_ITEMS   = 1900;
  localparam int WATCHDOG_LIMIT = 3000000;
  localparam int SETTLE_CYCLES  = 8;

  localparam int FLAW_NONE  = 0;
  localparam int FLAW_CRC   = 1;
  localparam int FLAW_END   = 2;
  localparam int FLAW_TRUNC = 3;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_t        in_payload = '0;
  logic       out_valid;
  out_t       out_payload;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = CFG_SHORT_START;
  logic [7:0] cfg_data = '0;
  int         fail_count;
  int         pending;
  int         idle_cycles = 0;
  int         item_count = 0;
  logic       no_idle = 1'b0;
  logic [7:0] cur_short = SHORT_START_RST;
  logic [7:0] cur_long = LONG_START_RST;
  logic [7:0] cur_end = END_BYTE_RST;

  resyncing_crc_frame_deframer #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_payload (in_payload),
    .out_valid  (out_valid),
    .out_payload(out_payload),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  rcfd_result_checker #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_payload (in_payload),
    .out_valid  (out_valid),
    .out_payload(out_payload),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 60);
  endfunction

  task automatic issue(logic [1:0] op, logic [7:0] data, logic [8:0] idx);
    in_t cmd;
    int  gap;
    cmd.operation  = op;
    cmd.data_byte  = data;
    cmd.read_index = idx;
    start <= 1'b1;
    in_payload <= cmd;
    do @(posedge clk); while (busy);
    item_count++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic push_byte(logic [7:0] b);
    issue(OP_PUSH, b, 9'($urandom));
  endtask

  task automatic scan_buffer();
    issue(OP_SCAN, 8'($urandom), 9'($urandom));
  endtask

  task automatic read_byte(logic [8:0] idx);
    issue(OP_READ, 8'($urandom), idx);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_framing(logic [7:0] s, logic [7:0] l, logic [7:0] e);
    logic [7:0] vals [3];
    logic [1:0] idxs [3];
    vals = '{s, l, e};
    idxs = '{CFG_SHORT_START, CFG_LONG_START, CFG_END_BYTE};
    wait_drained();
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
    cur_short = s;
    cur_long = l;
    cur_end = e;
  endtask

  function automatic logic [15:0] frame_crc(logic [7:0] body [$]);
    logic [15:0] crc;
    crc = CRC_INIT;
    foreach (body[i]) begin
      crc = crc ^ {body[i], 8'h00};
      for (int b = 0; b < 8; b++) begin
        if ((crc & CRC_MSB) != 16'h0) crc = (crc << 1) ^ CRC_POLY;
        else crc = crc << 1;
      end
    end
    return crc;
  endfunction

  task automatic push_frame(logic is_long, int len, int flaw);
    logic [7:0]  body [$];
    logic [7:0]  wire_bytes [$];
    logic [15:0] crc;
    int          cut;
    for (int i = 0; i < len; i++) body = {body, 8'($urandom)};
    crc = frame_crc(body);
    if (flaw == FLAW_CRC) crc = crc ^ (16'h1 << $urandom_range(0, 15));
    if (is_long) begin
      wire_bytes = {wire_bytes, cur_long};
      wire_bytes = {wire_bytes, 8'(len >> 8)};
    end else begin
      wire_bytes = {wire_bytes, cur_short};
    end
    wire_bytes = {wire_bytes, 8'(len)};
    foreach (body[i]) wire_bytes = {wire_bytes, body[i]};
    wire_bytes = {wire_bytes, crc[15:8]};
    wire_bytes = {wire_bytes, crc[7:0]};
    wire_bytes = {wire_bytes,
                  (flaw == FLAW_END) ? cur_end ^ 8'($urandom_range(1, 255)) : cur_end};
    if (flaw == FLAW_TRUNC) begin
      cut = $urandom_range(1, 3);
      repeat (cut) void'(wire_bytes.pop_back());
    end
    foreach (wire_bytes[i]) push_byte(wire_bytes[i]);
  endtask

  task automatic random_sequence();
    int r;
    int len;
    int flaw;
    logic is_long;
    logic [7:0] v;
    no_idle = ($urandom_range(0, 4) == 0);
    r = $urandom_range(0, 99);
    if (r < 72) begin
      repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
      is_long = $urandom_range(0, 1);
      if ($urandom_range(0, 149) == 0) len = is_long ? $urandom_range(256, 512) : 255;
      else len = $urandom_range(1, 12);
      r = $urandom_range(0, 99);
      flaw = r < 80 ? FLAW_NONE : r < 87 ? FLAW_CRC : r < 94 ? FLAW_END : FLAW_TRUNC;
      push_frame(is_long, len, flaw);
      scan_buffer();
      repeat ($urandom_range(0, 3))
        read_byte($urandom_range(0, 3) == 0 ? 9'($urandom) : 9'($urandom_range(0, len)));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 5))
          0: issue(OP_NONE, 8'($urandom), 9'($urandom));
          1: read_byte(9'($urandom));
          2: scan_buffer();
          3: begin
            v = $urandom_range(0, 1) ? cur_short : cur_long;
            push_byte(v);
            push_byte(8'h00);
            if (v == cur_long) push_byte(8'h00);
          end
          default: push_byte(8'($urandom));
        endcase
      end
    end
  endtask

  initial begin
    logic [7:0] fill_v;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at reset framing
    read_byte(9'd0);
    read_byte(9'd511);
    issue(OP_NONE, 8'hFF, 9'h1FF);
    scan_buffer();
    push_frame(1'b0, 1, FLAW_NONE);
    scan_buffer();
    read_byte(9'd0);
    read_byte(9'd1);
    push_frame(1'b0, 1, FLAW_CRC);
    scan_buffer();
    push_byte(cur_short);
    push_byte(8'h00);
    push_byte(8'hFF);
    scan_buffer();
    push_byte(cur_long);
    push_byte(8'h00);
    scan_buffer();

    // overflow of the receive buffer, then a maximum length frame
    set_framing(8'h00, 8'hFF, 8'h00);
    do fill_v = 8'($urandom); while (fill_v == cur_short || fill_v == cur_long);
    repeat (BUFFER_DEPTH + 6) push_byte(fill_v);
    scan_buffer();
    push_frame(1'b1, MAX_PAYLOAD, FLAW_NONE);
    scan_buffer();
    read_byte(9'd511);
    read_byte(9'd256);
    push_frame(1'b1, 2, FLAW_END);
    scan_buffer();

    set_framing(SHORT_START_RST, LONG_START_RST, END_BYTE_RST);
    while (item_count < TARGET_ITEMS) begin
      if (item_count > 1250 && cur_short != 8'h7E) set_framing(8'h7E, 8'h7E, 8'hFF);
      else if (item_count > 1600 && cur_short == 8'h7E)
        set_framing(8'($urandom), 8'($urandom), 8'($urandom));
      if ($urandom_range(0, 39) == 0) wait_drained();
      random_sequence();
    end

    wait_drained();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
